FILE: rtl/reverse_pool_index_builder_unit_macros.svh
// Assertion macros shared by the reverse pool index builder RTL.
`ifndef REVERSE_POOL_INDEX_BUILDER_UNIT_MACROS_SVH
`define REVERSE_POOL_INDEX_BUILDER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RPIB_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("rpib assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define RPIB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("rpib assertion failed");

`endif

FILE: rtl/rpib_pkg.sv
// Types and constants of the reverse pool index builder.
package rpib_pkg;

	localparam int PARENT_W    = 10;
	localparam int VALUE_W     = 17;
	localparam int TOTAL_W     = 15;
	localparam int STRIDE_W    = 5;
	localparam int PCOUNT_W    = 11;
	localparam int SLOT_W      = 4;
	localparam int PADDR_W     = 4;
	localparam int PDATA_W     = 32;

	localparam logic [STRIDE_W-1:0] STRIDE_RESET = 5'd16;
	localparam logic [PCOUNT_W-1:0] PCOUNT_RESET = 11'd1024;

	typedef enum logic [1:0] {
		OP_ADD   = 2'd0,
		OP_READ  = 2'd1,
		OP_CLEAR = 2'd2,
		OP_NONE  = 2'd3
	} op_e_t;

	typedef enum logic [1:0] {
		REG_FOUR_WAY = 2'd0,
		REG_STRIDE   = 2'd1,
		REG_PCOUNT   = 2'd2,
		REG_UNUSED   = 2'd3
	} reg_idx_t;

	typedef struct packed {
		op_e_t               operation;
		logic [PARENT_W-1:0] parent_index;
		logic [1:0]          rotation;
		logic [1:0]          direction;
		logic [SLOT_W-1:0]   slot;
	} in_item_t;

	typedef struct packed {
		logic [VALUE_W-1:0] entry_value;
		logic               bad_address;
	} out_item_t;

endpackage

FILE: rtl/reverse_pool_index_builder_unit.sv
// Top level of the reverse pool index builder: fill counts, banked slot store, pipeline.
//
// Usage: items come in on in_valid/in_stall/in_data. An add (operation 0) stores the
// child in its parent's next slot, a read (1) returns one out_data transaction, a clear
// (2) empties every row. Adds, clears and no-ops give no result.
// Reads come out on out_valid/out_stall/out_data through stage 1, stage 2 and the output
// register; one item is taken per cycle while the output keeps up and no clear runs.
// Each item reads its parent's fill count from a one-port-read memory at acceptance,
// and adds/reads touch four slot memories one stage later, banked by direction in
// four-way mode and by the parent's two low bits otherwise. A fill count written by the
// previous item is forwarded. A clear holds in_stall high while a sweep zeroes the
// fill count memory one entry per cycle. After reset the same sweep runs before the
// first item is taken; configuration writes go through at any time. When out_stall
// holds a result, the whole pipeline freezes and in_stall rises; nothing is dropped.
// Registers sit on the APB port at byte addresses 0, 4, 8.
`include "reverse_pool_index_builder_unit_macros.svh"

module reverse_pool_index_builder_unit #(
	parameter int MAX_PARENTS  = 1024,
	parameter int MAX_STRIDE   = 16,
	parameter int MAX_CHILDREN = 16384
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  rpib_pkg::in_item_t                  in_data,
	output logic                                out_valid,
	input  logic                                out_stall,
	output rpib_pkg::out_item_t                 out_data,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [rpib_pkg::PADDR_W-1:0]        paddr,
	input  logic [rpib_pkg::PDATA_W-1:0]        pwdata,
	output logic [rpib_pkg::PDATA_W-1:0]        prdata,
	output logic                                pready
);

	localparam int PA_W       = (MAX_PARENTS > 1) ? $clog2(MAX_PARENTS) : 1;
	localparam int FW         = $clog2(MAX_STRIDE + 1);
	localparam int OW         = (MAX_STRIDE > 1) ? $clog2(MAX_STRIDE) : 1;
	localparam int BANK_DEPTH = MAX_PARENTS * MAX_STRIDE;
	localparam int BA_W       = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
	localparam int VW         = rpib_pkg::VALUE_W;
	localparam int TW         = rpib_pkg::TOTAL_W;

	// configuration registers
	logic                          four_way_q;
	logic [rpib_pkg::STRIDE_W-1:0] stride_q;
	logic [rpib_pkg::PCOUNT_W-1:0] pcount_q;
	logic                          cfg_wr;
	rpib_pkg::reg_idx_t            cfg_sel;

	// control
	logic            advance;
	logic            accept;
	logic            clearing_q;
	logic [PA_W-1:0] clr_cnt_q;
	logic            clear_start;
	logic [TW-1:0]   child_total_q;

	// stage 1
	logic               valid_s1;
	rpib_pkg::in_item_t item_s1;
	logic [FW-1:0]      fill_rd_s1;
	logic               fwd_hit_s1;
	logic [FW-1:0]      fwd_val_s1;

	logic [FW-1:0]  fill_cur;
	logic [FW-1:0]  stride_eff;
	logic           parent_ok;
	logic           is_add;
	logic           is_read;
	logic           add_ok;
	logic           add_write;
	logic           read_bad;
	logic           mem_re;
	logic [OW-1:0]  read_idx;
	logic [OW-1:0]  offset;
	logic [PARENT_W_L-1:0] row_q_idx;
	logic [BA_W-1:0] mem_addr;
	logic [3:0]     bank_we;
	logic [3:0][VW-1:0] bank_wdata;
	logic [1:0]     read_bank;
	logic [VW-1:0]  empty_value;

	localparam int PARENT_W_L = rpib_pkg::PARENT_W;

	// fill count memory port
	logic            fill_we;
	logic [PA_W-1:0] fill_waddr;
	logic [FW-1:0]   fill_wdata;
	logic [FW-1:0]   fill_mem [MAX_PARENTS];

	// stage 2
	logic               valid_s2;
	logic               bad_s2;
	logic               use_mem_s2;
	logic [VW-1:0]      value_s2;
	logic [1:0]         bank_s2;
	logic [3:0][VW-1:0] rd_data_s2;

	// output register
	logic                out_valid_q;
	rpib_pkg::out_item_t out_data_q;

	// ---------------- configuration port ----------------
	assign pready  = 1'b1;
	assign cfg_sel = rpib_pkg::reg_idx_t'(paddr[3:2]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			four_way_q <= 1'b0;
			stride_q   <= rpib_pkg::STRIDE_RESET;
			pcount_q   <= rpib_pkg::PCOUNT_RESET;
		end else if (cfg_wr) begin
			case (cfg_sel)
				rpib_pkg::REG_FOUR_WAY: four_way_q <= pwdata[0];
				rpib_pkg::REG_STRIDE:   stride_q   <= pwdata[rpib_pkg::STRIDE_W-1:0];
				rpib_pkg::REG_PCOUNT:   pcount_q   <= pwdata[rpib_pkg::PCOUNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_sel)
			rpib_pkg::REG_FOUR_WAY: prdata = rpib_pkg::PDATA_W'(four_way_q);
			rpib_pkg::REG_STRIDE:   prdata = rpib_pkg::PDATA_W'(stride_q);
			rpib_pkg::REG_PCOUNT:   prdata = rpib_pkg::PDATA_W'(pcount_q);
			default:                prdata = '0;
		endcase
	end

	// ---------------- handshake ----------------
	assign advance     = !out_valid_q || !out_stall;
	assign clear_start = valid_s1 && (item_s1.operation == rpib_pkg::OP_CLEAR) && advance;
	assign in_stall    = clearing_q || !advance ||
		(valid_s1 && (item_s1.operation == rpib_pkg::OP_CLEAR));
	assign accept      = in_valid && !in_stall;

	// ---------------- stage 1 decode ----------------
	always_comb begin
		if (stride_q == '0)
			stride_eff = FW'(1);
		else if (32'(stride_q) > 32'(MAX_STRIDE))
			stride_eff = FW'(MAX_STRIDE);
		else
			stride_eff = FW'(stride_q);
	end

	assign fill_cur  = fwd_hit_s1 ? fwd_val_s1 : fill_rd_s1;
	assign parent_ok = (32'(item_s1.parent_index) < 32'(pcount_q)) &&
		(32'(item_s1.parent_index) < 32'(MAX_PARENTS));
	assign is_add    = valid_s1 && (item_s1.operation == rpib_pkg::OP_ADD);
	assign is_read   = valid_s1 && (item_s1.operation == rpib_pkg::OP_READ);
	assign add_ok    = is_add && parent_ok && (32'(child_total_q) < 32'(MAX_CHILDREN));
	assign add_write = add_ok && (fill_cur < stride_eff);
	assign read_bad  = !parent_ok || (32'(item_s1.slot) >= 32'(stride_eff));
	assign mem_re    = is_read && !read_bad && (fill_cur != '0);

	// past the fill, repeat the last stored entry
	assign read_idx  = (32'(item_s1.slot) < 32'(fill_cur)) ? OW'(item_s1.slot)
		: OW'(fill_cur - FW'(1));
	assign offset    = is_add ? OW'(fill_cur) : read_idx;
	assign row_q_idx = four_way_q ? item_s1.parent_index
		: (item_s1.parent_index >> 2);
	assign mem_addr  = BA_W'(32'(row_q_idx) * 32'(MAX_STRIDE) + 32'(offset));
	assign read_bank = four_way_q ? item_s1.direction : item_s1.parent_index[1:0];
	assign empty_value = four_way_q ? {child_total_q, 2'b00} : VW'(child_total_q);

	always_comb begin
		for (int b = 0; b < 4; b++) begin
			bank_we[b] = add_write &&
				(four_way_q || (item_s1.parent_index[1:0] == 2'(b)));
			bank_wdata[b] = four_way_q ? {child_total_q, 2'(2'(b) - item_s1.rotation)}
				: VW'(child_total_q);
		end
	end

	// ---------------- slot store banks ----------------
	for (genvar g = 0; g < 4; g++) begin : g_bank
		logic [VW-1:0] mem [BANK_DEPTH];

		always_ff @(posedge clk) begin
			if (advance && bank_we[g])
				mem[mem_addr] <= bank_wdata[g];
			if (advance && mem_re)
				rd_data_s2[g] <= mem[mem_addr];
		end
	end

	// ---------------- fill count memory ----------------
	assign fill_we    = clearing_q || (advance && add_write);
	assign fill_waddr = clearing_q ? clr_cnt_q : PA_W'(item_s1.parent_index);
	assign fill_wdata = clearing_q ? '0 : (fill_cur + FW'(1));

	always_ff @(posedge clk) begin
		if (fill_we)
			fill_mem[fill_waddr] <= fill_wdata;
		if (advance)
			fill_rd_s1 <= fill_mem[PA_W'(in_data.parent_index)];
	end

	// ---------------- control registers ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1      <= 1'b0;
			fwd_hit_s1    <= 1'b0;
			valid_s2      <= 1'b0;
			out_valid_q   <= 1'b0;
			clearing_q    <= 1'b1;
			clr_cnt_q     <= '0;
			child_total_q <= '0;
		end else begin
			if (advance) begin
				valid_s1    <= accept;
				// forward the count written this edge to the item entering now
				fwd_hit_s1  <= add_write && (item_s1.parent_index == in_data.parent_index);
				valid_s2    <= is_read;
				out_valid_q <= valid_s2;
			end
			if (clearing_q) begin
				clr_cnt_q <= clr_cnt_q + PA_W'(1);
				if (clr_cnt_q == PA_W'(MAX_PARENTS - 1))
					clearing_q <= 1'b0;
			end else if (clear_start) begin
				clearing_q <= 1'b1;
				clr_cnt_q  <= '0;
			end
			if (clear_start)
				child_total_q <= '0;
			else if (advance && add_ok)
				child_total_q <= child_total_q + TW'(1);
		end
	end

	// ---------------- payload registers ----------------
	always_ff @(posedge clk) begin
		if (advance) begin
			item_s1    <= in_data;
			fwd_val_s1 <= fill_wdata;
			bad_s2     <= read_bad;
			use_mem_s2 <= !read_bad && (fill_cur != '0);
			value_s2   <= read_bad ? '0 : empty_value;
			bank_s2    <= read_bank;
			out_data_q.entry_value <= use_mem_s2 ? rd_data_s2[bank_s2] : value_s2;
			out_data_q.bad_address <= bad_s2;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// ---------------- assertions ----------------
	`RPIB_ASSERT_IMPL(a_sweep_alone, clk, arst_n, clearing_q, !valid_s1)
	`RPIB_ASSERT_IMPL(a_fill_bound, clk, arst_n, fill_we, 32'(fill_wdata) <= 32'(MAX_STRIDE))
	`RPIB_ASSERT_NEXT(a_clear_sweeps, clk, arst_n, clear_start, clearing_q && clr_cnt_q == '0)
	`RPIB_ASSERT_IMPL(a_result_held, clk, arst_n, $fell(out_valid_q), !$past(out_stall))

endmodule

FILE: tb/tb.sv
// Testbench for the reverse pool index builder: directed table, random phases, scoreboard.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import rpib_pkg::*;

	localparam int MAX_PARENTS  = 1024;
	localparam int MAX_STRIDE   = 16;
	localparam int MAX_CHILDREN = 16384;

	localparam in_item_t  NO_ITEM = '{OP_NONE, 10'd0, 2'd0, 2'd0, 4'd0};
	localparam out_item_t NO_WANT = '{17'd0, 1'b0};

	// reg_sel other than REG_UNUSED makes the row a register write
	typedef struct packed {
		reg_idx_t         reg_sel;
		logic [10:0]      reg_val;
		in_item_t         item;
		logic             typed;
		out_item_t        want;
	} plan_row_t;

	typedef struct packed {
		logic             four_way;
		logic [4:0]       stride;
		logic [10:0]      pcount;
		logic [15:0]      n_items;
		logic             calm;
		logic             flood;
	} phase_t;

	plan_row_t plan [$] = '{
		'{REG_UNUSED, 11'd0, '{OP_READ, 10'd0, 2'd0, 2'd0, 4'd0}, 1'b1, '{17'd0, 1'b0}},
		'{REG_UNUSED, 11'd0, '{OP_READ, 10'd1023, 2'd0, 2'd3, 4'd15}, 1'b1, '{17'd0, 1'b0}},
		'{REG_UNUSED, 11'd0, '{OP_ADD, 10'd0, 2'd0, 2'd0, 4'd0}, 1'b0, NO_WANT},
		'{REG_UNUSED, 11'd0, '{OP_ADD, 10'd0, 2'd3, 2'd0, 4'd0}, 1'b0, NO_WANT},
		'{REG_UNUSED, 11'd0, '{OP_READ, 10'd0, 2'd0, 2'd0, 4'd1}, 1'b1, '{17'd1, 1'b0}},
		'{REG_UNUSED, 11'd0, '{OP_READ, 10'd0, 2'd0, 2'd0, 4'd15}, 1'b1, '{17'd1, 1'b0}},
		'{REG_UNUSED, 11'd0, '{OP_READ, 10'd5, 2'd0, 2'd0, 4'd3}, 1'b1, '{17'd2, 1'b0}},
		'{REG_UNUSED, 11'd0, '{OP_ADD, 10'd1023, 2'd1, 2'd0, 4'd0}, 1'b0, NO_WANT},
		'{REG_UNUSED, 11'd0, '{OP_READ, 10'd1023, 2'd0, 2'd2, 4'd0}, 1'b0, NO_WANT},
		'{REG_UNUSED, 11'd0, '{OP_NONE, 10'd1023, 2'd3, 2'd3, 4'd15}, 1'b0, NO_WANT},
		'{REG_UNUSED, 11'd0, '{OP_READ, 10'd0, 2'd0, 2'd3, 4'd0}, 1'b0, NO_WANT},
		'{REG_UNUSED, 11'd0, '{OP_CLEAR, 10'd0, 2'd0, 2'd0, 4'd0}, 1'b0, NO_WANT},
		'{REG_UNUSED, 11'd0, '{OP_READ, 10'd0, 2'd0, 2'd0, 4'd0}, 1'b1, '{17'd0, 1'b0}},
		'{REG_FOUR_WAY, 11'd1, NO_ITEM, 1'b0, NO_WANT},
		'{REG_STRIDE, 11'd2, NO_ITEM, 1'b0, NO_WANT},
		'{REG_PCOUNT, 11'd3, NO_ITEM, 1'b0, NO_WANT},
		'{REG_UNUSED, 11'd0, '{OP_ADD, 10'd2, 2'd1, 2'd0, 4'd0}, 1'b0, NO_WANT},
		'{REG_UNUSED, 11'd0, '{OP_ADD, 10'd2, 2'd0, 2'd0, 4'd0}, 1'b0, NO_WANT},
		'{REG_UNUSED, 11'd0, '{OP_ADD, 10'd2, 2'd2, 2'd0, 4'd0}, 1'b0, NO_WANT},
		'{REG_UNUSED, 11'd0, '{OP_ADD, 10'd3, 2'd0, 2'd0, 4'd0}, 1'b0, NO_WANT},
		'{REG_UNUSED, 11'd0, '{OP_READ, 10'd2, 2'd0, 2'd0, 4'd0}, 1'b0, NO_WANT},
		'{REG_UNUSED, 11'd0, '{OP_READ, 10'd2, 2'd0, 2'd1, 4'd1}, 1'b0, NO_WANT},
		'{REG_UNUSED, 11'd0, '{OP_READ, 10'd2, 2'd0, 2'd0, 4'd2}, 1'b1, '{17'd0, 1'b1}},
		'{REG_UNUSED, 11'd0, '{OP_READ, 10'd3, 2'd0, 2'd0, 4'd0}, 1'b1, '{17'd0, 1'b1}},
		'{REG_UNUSED, 11'd0, '{OP_READ, 10'd1, 2'd0, 2'd2, 4'd1}, 1'b0, NO_WANT},
		'{REG_STRIDE, 11'd0, NO_ITEM, 1'b0, NO_WANT},
		'{REG_UNUSED, 11'd0, '{OP_READ, 10'd2, 2'd0, 2'd3, 4'd1}, 1'b1, '{17'd0, 1'b1}},
		'{REG_UNUSED, 11'd0, '{OP_READ, 10'd2, 2'd0, 2'd3, 4'd0}, 1'b0, NO_WANT},
		'{REG_STRIDE, 11'd31, NO_ITEM, 1'b0, NO_WANT},
		'{REG_UNUSED, 11'd0, '{OP_READ, 10'd2, 2'd0, 2'd2, 4'd15}, 1'b0, NO_WANT}
	};

	// a mode change starts with a clear so no read lands on an unwritten entry
	phase_t phases [$] = '{
		'{1'b0, 5'd16, 11'd1024, 16'd250, 1'b1, 1'b0},
		'{1'b1, 5'd1, 11'd1, 16'd150, 1'b0, 1'b0},
		'{1'b1, 5'd16, 11'd1024, 16'd250, 1'b0, 1'b0},
		'{1'b0, 5'd4, 11'd700, 16'd200, 1'b0, 1'b0},
		'{1'b0, 5'd31, 11'd2047, 16'd150, 1'b0, 1'b0},
		'{1'b1, 5'd0, 11'd512, 16'd150, 1'b0, 1'b0},
		'{1'b1, 5'd7, 11'd0, 16'd40, 1'b0, 1'b0},
		'{1'b0, 5'd3, 11'd200, 16'd200, 1'b0, 1'b0},
		'{1'b1, 5'd16, 11'd1024, 16'd17400, 1'b0, 1'b1},
		'{1'b1, 5'd16, 11'd1024, 16'd150, 1'b0, 1'b0},
		'{1'b1, 5'd9, 11'd1000, 16'd200, 1'b0, 1'b0}
	};

	logic                clk;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	in_item_t            in_data = NO_ITEM;
	logic                out_valid;
	logic                out_stall = 1'b0;
	out_item_t           out_data;
	logic                psel = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite = 1'b0;
	logic [PADDR_W-1:0]  paddr = '0;
	logic [PDATA_W-1:0]  pwdata = '0;
	logic [PDATA_W-1:0]  prdata;
	logic                pready;

	// mirror of the block's state and registers
	logic                four_way_q = 1'b0;
	logic [4:0]          stride_q = STRIDE_RESET;
	logic [10:0]         pcount_q = PCOUNT_RESET;
	logic [4:0]          row_fill [MAX_PARENTS];
	logic [VALUE_W-1:0]  entry_mem [MAX_PARENTS * 4 * MAX_STRIDE];
	int                  children_seen = 0;

	out_item_t           pending_reads [$];
	out_item_t           oldest_read;
	int                  errors = 0;
	bit                  calm = 1'b0;

	reverse_pool_index_builder_unit #(
		.MAX_PARENTS(MAX_PARENTS),
		.MAX_STRIDE(MAX_STRIDE),
		.MAX_CHILDREN(MAX_CHILDREN)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("tb NOT OK");
		$finish;
	end

	always @(posedge clk) begin
		out_stall <= !calm && ($urandom_range(0, 99) < 32);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_reads.size() == 0) begin
				$display("%0t: unexpected read result, actual %0d/%0d", $time,
					out_data.entry_value, out_data.bad_address);
				errors++;
			end else begin
				oldest_read = pending_reads.pop_front();
				if (out_data.entry_value !== oldest_read.entry_value) begin
					$display("%0t: entry_value expected %0d actual %0d", $time,
						oldest_read.entry_value, out_data.entry_value);
					errors++;
				end
				if (out_data.bad_address !== oldest_read.bad_address) begin
					$display("%0t: bad_address expected %0d actual %0d", $time,
						oldest_read.bad_address, out_data.bad_address);
					errors++;
				end
			end
		end
	end

	// Advance the index mirror by one accepted transaction; made is set on reads.
	task automatic apply_to_index(input in_item_t it, output bit made, output out_item_t res);
		int stride;
		int fill;
		int row;
		int p;
		int j;
		stride = (stride_q == 0) ? 1 : (stride_q > MAX_STRIDE) ? MAX_STRIDE : int'(stride_q);
		p = int'(it.parent_index);
		made = 1'b0;
		res = NO_WANT;
		case (it.operation)
			OP_ADD: begin
				if (p < int'(pcount_q) && children_seen < MAX_CHILDREN) begin
					fill = int'(row_fill[p]);
					if (fill < stride) begin
						if (four_way_q) begin
							for (j = 0; j < 4; j++) begin
								row = p * 4 + ((j + int'(it.rotation)) % 4);
								entry_mem[row * MAX_STRIDE + fill] = 17'(children_seen * 4 + j);
							end
						end else begin
							entry_mem[p * MAX_STRIDE + fill] = 17'(children_seen);
						end
						row_fill[p] = 5'(fill + 1);
					end
					children_seen++;
				end
			end
			OP_READ: begin
				made = 1'b1;
				if (p >= int'(pcount_q) || int'(it.slot) >= stride) begin
					res.bad_address = 1'b1;
				end else begin
					fill = int'(row_fill[p]);
					row = four_way_q ? p * 4 + int'(it.direction) : p;
					if (fill == 0)
						res.entry_value = 17'(four_way_q ? children_seen * 4 : children_seen);
					else
						res.entry_value = entry_mem[row * MAX_STRIDE +
							((int'(it.slot) < fill) ? int'(it.slot) : fill - 1)];
				end
			end
			OP_CLEAR: begin
				foreach (row_fill[i])
					row_fill[i] = '0;
				children_seen = 0;
			end
			default: ;
		endcase
	endtask

	// Present one transaction, hold it until taken, then record what it should produce.
	task automatic send_item(input in_item_t it, input bit typed, input out_item_t want);
		out_item_t guess;
		bit made;
		while (!calm && $urandom_range(0, 99) < 32) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		apply_to_index(it, made, guess);
		if (made)
			pending_reads.push_back(typed ? want : guess);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [10:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= 32'(val);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_FOUR_WAY: four_way_q = val[0];
			REG_STRIDE:   stride_q = val[4:0];
			REG_PCOUNT:   pcount_q = val;
			default: ;
		endcase
	endtask

	// Drop valid, let every read come back and the add pipeline drain.
	task automatic settle_idle();
		in_valid <= 1'b0;
		while (pending_reads.size() != 0)
			@(posedge clk);
		repeat (8)
			@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	// Mostly well-formed traffic on a small parent pool; flood piles up adds past capacity.
	function automatic in_item_t random_item(int base, bit flood);
		in_item_t it;
		int pick;
		int p;
		pick = $urandom_range(0, 199);
		if (flood)
			it.operation = (pick < 194) ? OP_ADD : OP_READ;
		else if (pick < 92)
			it.operation = OP_ADD;
		else if (pick < 188)
			it.operation = OP_READ;
		else if (pick < 198)
			it.operation = OP_NONE;
		else
			it.operation = OP_CLEAR;
		pick = $urandom_range(0, 99);
		if (flood)
			p = (it.operation == OP_ADD) ? $urandom_range(0, 999) : $urandom_range(0, 1023);
		else if (pick < 80)
			p = base + $urandom_range(0, 7);
		else if (pick < 90)
			p = $urandom_range(0, 1023);
		else
			p = int'(pcount_q) - 1 + $urandom_range(0, 2);
		it.parent_index = p[9:0];
		it.rotation = 2'($urandom_range(0, 3));
		it.direction = 2'($urandom_range(0, 3));
		it.slot = 4'($urandom_range(0, 15));
		return it;
	endfunction

	initial begin
		int base;
		int top;
		in_item_t clear_item;
		clear_item = '{OP_CLEAR, 10'd0, 2'd0, 2'd0, 4'd0};
		foreach (row_fill[i])
			row_fill[i] = '0;
		repeat (12)
			@(posedge clk);
		arst_n <= 1'b1;

		foreach (plan[i]) begin
			if (plan[i].reg_sel != REG_UNUSED) begin
				settle_idle();
				write_reg(plan[i].reg_sel, plan[i].reg_val);
			end else begin
				send_item(plan[i].item, plan[i].typed, plan[i].want);
			end
		end

		foreach (phases[k]) begin
			settle_idle();
			calm = phases[k].calm;
			write_reg(REG_STRIDE, 11'(phases[k].stride));
			write_reg(REG_PCOUNT, phases[k].pcount);
			if (phases[k].four_way != four_way_q) begin
				write_reg(REG_FOUR_WAY, 11'(phases[k].four_way));
				send_item(clear_item, 1'b0, NO_WANT);
			end
			top = (int'(pcount_q) > 8) ? int'(pcount_q) - 8 : 0;
			if (top > MAX_PARENTS - 8)
				top = MAX_PARENTS - 8;
			base = $urandom_range(0, top);
			repeat (int'(phases[k].n_items))
				send_item(random_item(base, phases[k].flood), 1'b0, NO_WANT);
		end

		settle_idle();
		repeat (16)
			@(posedge clk);
		if (errors == 0 && pending_reads.size() == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

endmodule

FILE: files.f
+incdir+rtl
rtl/rpib_pkg.sv
rtl/reverse_pool_index_builder_unit.sv
tb/tb.sv
